// ----- rtl/core/srp_pkg.sv -----
// ----------------------------------------------------------------------------
// srp_pkg
// Shared constants and types of the seeded random permutation block.
// ----------------------------------------------------------------------------
package srp_pkg;

	localparam int VALUE_W         = 16;
	localparam int SEED_W          = 64;
	localparam int DRAW_W          = 32;
	localparam int SH_A            = 23;
	localparam int SH_B            = 18;
	localparam int SH_C            = 5;
	localparam int DEF_STORE_DEPTH = 64;
	localparam int DEF_VALUE_BITS  = 16;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// ----- rtl/core/srp_rem_unit.sv -----
// ----------------------------------------------------------------------------
// srp_rem_unit
// Iterative restoring remainder unit, one dividend bit per cycle.
// ----------------------------------------------------------------------------
module srp_rem_unit #(
	parameter int DIV_W = 7,
	parameter int NUM_W = srp_pkg::DRAW_W
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [NUM_W-1:0]   dividend,
	input  logic [DIV_W-1:0]   divisor,
	output srp_pkg::div_stat_t stat,
	output logic [DIV_W-1:0]   rem
);

	localparam int CW = (NUM_W > 1) ? $clog2(NUM_W) : 1;

	logic [NUM_W-1:0] dvd_q;
	logic [DIV_W-1:0] dsr_q;
	logic [DIV_W-1:0] rem_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   rem_sh;
	logic [DIV_W:0]   rem_sub;

	assign rem_sh  = {rem_q, dvd_q[NUM_W-1]};
	assign rem_sub = rem_sh - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == CW'(NUM_W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dsr_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (rem_sh >= {1'b0, dsr_q}) begin
				rem_q <= rem_sub[DIV_W-1:0];
			end else begin
				rem_q <= rem_sh[DIV_W-1:0];
			end
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign rem       = rem_q;

endmodule

// ----- rtl/core/seeded_random_permutation_top.sv -----
// ----------------------------------------------------------------------------
// seeded_random_permutation_top
// Collects a batch of words and returns it shuffled by a seeded generator.
// ----------------------------------------------------------------------------
// Input words (element_value, last_element) are taken on in_valid with
// in_stall low, one per cycle while the block is loading. A word marked last
// ends the batch; words beyond STORE_DEPTH are dropped and flag overflow.
// The shuffle then runs with in_stall high: the generator is seeded and two
// draws are discarded, then each stored word is handled by a draw, the 32-step
// remainder unit (one bit a cycle) and four store accesses for the swap.
// Results (out_value, out_last, overflow) leave from an output register that is
// loaded from the store one word at a time; out_stall holds the
// register and the block waits. After the word marked out_last is taken the
// block loads again in the next cycle. The seed register is written through
// cfg_we and cfg_wdata, by the user only while idle (not enforced by the
// block); the value held at the last input word is the one used. Reset clears
// the seed, the fill count and all control state; the store needs no clearing.
// ----------------------------------------------------------------------------
module seeded_random_permutation_top #(
	parameter int STORE_DEPTH = srp_pkg::DEF_STORE_DEPTH,
	parameter int VALUE_BITS  = srp_pkg::DEF_VALUE_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [srp_pkg::SEED_W-1:0] cfg_wdata,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [srp_pkg::VALUE_W-1:0] element_value,
	input  logic                       last_element,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [srp_pkg::VALUE_W-1:0] out_value,
	output logic                       out_last,
	output logic                       overflow
);

	localparam int VW      = srp_pkg::VALUE_W;
	localparam int SW      = (VALUE_BITS < VW) ? VALUE_BITS : VW;
	localparam int AW      = $clog2(STORE_DEPTH);
	localparam int CNT_W   = $clog2(STORE_DEPTH + 1);
	localparam int GW      = srp_pkg::SEED_W;
	localparam int DW      = srp_pkg::DRAW_W;

	typedef enum logic [3:0] {
		S_LOAD,
		S_SEED,
		S_DISC,
		S_GEN,
		S_DIV,
		S_RDI,
		S_RDJ,
		S_WRI,
		S_WRJ,
		S_ERD,
		S_ELD,
		S_EWT
	} state_t;

	state_t state_q;

	logic [GW-1:0]    seed_q;
	logic [GW-1:0]    gen_a_q;
	logic [GW-1:0]    gen_b_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;
	logic             ovf_q;
	logic             disc_q;
	logic [SW-1:0]    ti_q;
	logic             out_valid_q;
	logic [VW-1:0]    out_value_q;
	logic             out_last_q;
	logic             overflow_q;

	logic [SW-1:0]    mem [STORE_DEPTH];
	logic [SW-1:0]    rdata_q;
	logic [AW-1:0]    raddr;
	logic [AW-1:0]    waddr;
	logic [SW-1:0]    wdata;
	logic             mem_we;

	logic [GW-1:0]    gen_sum;
	logic [GW-1:0]    gen_x;
	logic [GW-1:0]    gen_b_nx;
	logic             in_acc;
	logic             store_room;

	logic                div_start;
	logic [CNT_W-1:0]    div_dsr;
	logic [CNT_W-1:0]    div_rem;
	srp_pkg::div_stat_t  div_stat;

	// xorshift128+ step
	assign gen_sum  = gen_a_q + gen_b_q;
	assign gen_x    = gen_a_q ^ (gen_a_q << srp_pkg::SH_A);
	assign gen_b_nx = gen_x ^ gen_b_q ^ (gen_x >> srp_pkg::SH_B) ^ (gen_b_q >> srp_pkg::SH_C);

	assign in_stall   = (state_q != S_LOAD);
	assign in_acc     = in_valid && (state_q == S_LOAD);
	assign store_room = (fill_q < CNT_W'(STORE_DEPTH));

	assign div_start = (state_q == S_GEN);
	assign div_dsr   = fill_q - i_q;

	srp_rem_unit #(
		.DIV_W(CNT_W),
		.NUM_W(DW)
	) u_rem (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(gen_sum[DW-1:0]),
		.divisor (div_dsr),
		.stat    (div_stat),
		.rem     (div_rem)
	);

	// store port selection
	always_comb begin
		raddr  = i_q[AW-1:0];
		waddr  = fill_q[AW-1:0];
		wdata  = element_value[SW-1:0];
		mem_we = 1'b0;
		case (state_q)
			S_LOAD: begin
				mem_we = in_acc && store_room;
			end
			S_RDJ: begin
				raddr = j_q[AW-1:0];
			end
			S_WRI: begin
				mem_we = 1'b1;
				waddr  = i_q[AW-1:0];
				wdata  = rdata_q;
			end
			S_WRJ: begin
				mem_we = 1'b1;
				waddr  = j_q[AW-1:0];
				wdata  = ti_q;
			end
			S_ERD: begin
				raddr = k_q[AW-1:0];
			end
			default: begin
				raddr = i_q[AW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_LOAD;
			seed_q      <= '0;
			gen_a_q     <= '0;
			gen_b_q     <= '0;
			fill_q      <= '0;
			ovf_q       <= 1'b0;
			disc_q      <= 1'b0;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
			out_value_q <= '0;
			out_last_q  <= 1'b0;
			overflow_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				seed_q <= cfg_wdata;
			end
			case (state_q)
				S_LOAD: begin
					if (in_acc) begin
						if (store_room) begin
							fill_q <= fill_q + 1'b1;
						end else begin
							ovf_q <= 1'b1;
						end
						if (last_element) begin
							state_q <= S_SEED;
						end
					end
				end
				S_SEED: begin
					gen_a_q <= seed_q;
					gen_b_q <= '0;
					disc_q  <= 1'b0;
					i_q     <= '0;
					state_q <= S_DISC;
				end
				S_DISC: begin
					gen_a_q <= gen_b_q;
					gen_b_q <= gen_b_nx;
					disc_q  <= 1'b1;
					if (disc_q) begin
						state_q <= S_GEN;
					end
				end
				S_GEN: begin
					gen_a_q <= gen_b_q;
					gen_b_q <= gen_b_nx;
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						j_q     <= i_q + div_rem;
						state_q <= S_RDI;
					end
				end
				S_RDI: begin
					state_q <= S_RDJ;
				end
				S_RDJ: begin
					state_q <= S_WRI;
				end
				S_WRI: begin
					state_q <= S_WRJ;
				end
				S_WRJ: begin
					i_q <= i_q + 1'b1;
					if (i_q == fill_q - 1'b1) begin
						k_q     <= '0;
						state_q <= S_ERD;
					end else begin
						state_q <= S_GEN;
					end
				end
				S_ERD: begin
					state_q <= S_ELD;
				end
				S_ELD: begin
					out_value_q <= VW'(rdata_q);
					out_last_q  <= (k_q == fill_q - 1'b1);
					overflow_q  <= ovf_q;
					out_valid_q <= 1'b1;
					state_q     <= S_EWT;
				end
				S_EWT: begin
					if (!out_stall) begin
						out_valid_q <= 1'b0;
						if (out_last_q) begin
							fill_q  <= '0;
							ovf_q   <= 1'b0;
							state_q <= S_LOAD;
						end else begin
							k_q     <= k_q + 1'b1;
							state_q <= S_ERD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	// ti_q is a plain data register
	always_ff @(posedge clk) begin
		if (state_q == S_RDJ) begin
			ti_q <= rdata_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_value = out_value_q;
	assign out_last  = out_last_q;
	assign overflow  = overflow_q;

	a_no_load_while_emit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> in_stall)
		else $error("input taken while a word is pending");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(STORE_DEPTH))
		else $error("fill count beyond store depth");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == S_DIV))
		else $error("remainder done outside wait state");

	a_swap_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RDJ) |-> (j_q < fill_q) && (j_q >= i_q))
		else $error("swap index out of range");

	a_reload_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last && !out_stall |=> !in_stall && (fill_q == '0))
		else $error("block not reloading after last word");

endmodule

// ----- bench/seeded_random_permutation_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seeded_random_permutation_top_tb
// Self-checking bench for the seeded batch shuffler.
// ----------------------------------------------------------------------------
// Batches of words are streamed in, and each returned batch is compared word by
// word with a local model of the xorshift128+ driven Fisher-Yates shuffle. A
// short plan covers single-word and short batches, all-zero and all-one values,
// and a seed change in the middle of a batch. With the seed at zero the
// generator draws only zeros, so those batches come back in input order and are
// typed in directly. Random batches follow: mostly short, some of exactly the
// store depth, and some that overflow the store and drop the words beyond it. The
// seed changes between batches and inside them. Sender gaps and receiver
// stalls are random, with stretches that have none.
// ----------------------------------------------------------------------------
module seeded_random_permutation_top_tb;

	localparam int VALUE_W     = srp_pkg::VALUE_W;
	localparam int SEED_W      = srp_pkg::SEED_W;
	localparam int DRAW_W      = srp_pkg::DRAW_W;
	localparam int SH_A        = srp_pkg::SH_A;
	localparam int SH_B        = srp_pkg::SH_B;
	localparam int SH_C        = srp_pkg::SH_C;
	localparam int DEPTH       = srp_pkg::DEF_STORE_DEPTH;
	localparam int RAND_WORDS  = 410;
	localparam int SETTLE      = 8;
	localparam int DRAIN       = 50;
	localparam int CYCLE_LIMIT = 400000;
	localparam int PLAN_LEN    = 20;

	typedef enum bit [0:0] {
		ACT_WORD,
		ACT_SEED
	} act_t;

	typedef struct packed {
		act_t              act;
		logic [SEED_W-1:0] data;
		bit                is_last;
		bit                typed;
	} plan_step_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               is_last;
		logic               ovf;
	} result_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [SEED_W-1:0]   cfg_wdata;
	logic                in_valid;
	logic                in_stall;
	logic [VALUE_W-1:0]  element_value;
	logic                last_element;
	logic                out_valid;
	logic                out_stall;
	logic [VALUE_W-1:0]  out_value;
	logic                out_last;
	logic                overflow;

	// shuffle model state
	logic [SEED_W-1:0]   seed_reg;
	logic [VALUE_W-1:0]  batch_store [DEPTH];
	int unsigned         batch_fill;
	logic                batch_ovf;
	logic [SEED_W-1:0]   gen_a;
	logic [SEED_W-1:0]   gen_b;

	result_t             expected_words [$];
	int unsigned         fail_cnt = 0;
	int unsigned         cycle_cnt = 0;
	int unsigned         burst_left;
	int unsigned         stall_mode = 0;
	int unsigned         stall_left = 0;

	plan_step_t plan [PLAN_LEN] = '{
		'{ACT_WORD, 64'h0000, 1'b1, 1'b1},
		'{ACT_WORD, 64'hFFFF, 1'b1, 1'b1},
		'{ACT_WORD, 64'h5555, 1'b0, 1'b1},
		'{ACT_WORD, 64'hAAAA, 1'b1, 1'b1},
		'{ACT_WORD, 64'h0001, 1'b0, 1'b1},
		'{ACT_WORD, 64'h0002, 1'b0, 1'b1},
		'{ACT_WORD, 64'h0004, 1'b0, 1'b1},
		'{ACT_WORD, 64'h8000, 1'b1, 1'b1},
		'{ACT_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0},
		'{ACT_WORD, 64'h1234, 1'b0, 1'b0},
		'{ACT_WORD, 64'h00FF, 1'b0, 1'b0},
		'{ACT_WORD, 64'hFF00, 1'b0, 1'b0},
		'{ACT_WORD, 64'h7FFF, 1'b1, 1'b0},
		'{ACT_SEED, 64'h0000_0000_0000_0001, 1'b0, 1'b0},
		'{ACT_WORD, 64'h0011, 1'b0, 1'b0},
		'{ACT_WORD, 64'h0022, 1'b0, 1'b0},
		'{ACT_WORD, 64'h0033, 1'b0, 1'b0},
		'{ACT_SEED, 64'h0123_4567_89AB_CDEF, 1'b0, 1'b0},
		'{ACT_WORD, 64'h0044, 1'b0, 1'b0},
		'{ACT_WORD, 64'h0055, 1'b1, 1'b0}
	};

	seeded_random_permutation_top u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.element_value (element_value),
		.last_element  (last_element),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.out_value     (out_value),
		.out_last      (out_last),
		.overflow      (overflow)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic logic [SEED_W-1:0] xorshift_draw();
		logic [SEED_W-1:0] x;
		logic [SEED_W-1:0] y;
		logic [SEED_W-1:0] sum;
		x     = gen_a;
		y     = gen_b;
		sum   = x + y;
		gen_a = y;
		x     = x ^ (x << SH_A);
		gen_b = x ^ y ^ (x >> SH_B) ^ (y >> SH_C);
		return sum;
	endfunction

	// store one word; a last word shuffles the batch and, when emit is set, queues its results
	function automatic void shuffle_word(logic [VALUE_W-1:0] v, bit is_last, bit emit);
		int unsigned       n;
		int unsigned       j;
		int unsigned       draw;
		logic [SEED_W-1:0] full_draw;
		logic [VALUE_W-1:0] t;
		result_t           r;
		if (batch_fill < DEPTH) begin
			batch_store[batch_fill] = v;
			batch_fill++;
		end else begin
			batch_ovf = 1'b1;
		end
		if (!is_last)
			return;
		n     = batch_fill;
		gen_a = seed_reg;
		gen_b = '0;
		full_draw = xorshift_draw();
		full_draw = xorshift_draw();
		for (int unsigned i = 0; i < n; i++) begin
			full_draw = xorshift_draw();
			draw = full_draw[DRAW_W-1:0];
			j = i + draw % (n - i);
			t              = batch_store[i];
			batch_store[i] = batch_store[j];
			batch_store[j] = t;
		end
		if (emit) begin
			for (int unsigned i = 0; i < n; i++) begin
				r.value   = batch_store[i];
				r.is_last = (i + 1 == n);
				r.ovf     = batch_ovf;
				expected_words.push_back(r);
			end
		end
		batch_fill = 0;
		batch_ovf  = 1'b0;
	endfunction

	function automatic logic [SEED_W-1:0] pick_seed();
		int unsigned sel;
		sel = $urandom_range(0, 7);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return {$urandom, $urandom};
	endfunction

	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return '0;
		if (sel == 1)
			return '1;
		return VALUE_W'($urandom_range(0, 16'hFFFF));
	endfunction

	task automatic send_word(input logic [VALUE_W-1:0] v, input bit is_last, input bit typed);
		int unsigned gap;
		result_t     r;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
			                                         : $urandom_range(1, 12);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid      <= 1'b1;
		element_value <= v;
		last_element  <= is_last;
		do
			@(posedge clk);
		while (in_stall);
		if (typed) begin
			r.value   = v;
			r.is_last = is_last;
			r.ovf     = 1'b0;
			expected_words.push_back(r);
		end
		shuffle_word(v, is_last, !typed);
	endtask

	task automatic write_seed(input logic [SEED_W-1:0] s);
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= s;
		@(posedge clk);
		seed_reg = s;
		cfg_we <= 1'b0;
	endtask

	// receiver stall pattern: free running, random, or mostly stalled
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = $urandom_range(0, 2);
			stall_left = $urandom_range(50, 300);
		end
		stall_left--;
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= ($urandom_range(0, 1) == 1);
			end
			default: begin
				out_stall <= ($urandom_range(0, 7) != 0);
			end
		endcase
	end

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				fail_cnt++;
				if (fail_cnt <= 10)
					$display("unexpected word: value %h last %b overflow %b",
					         out_value, out_last, overflow);
			end else begin
				want = expected_words.pop_front();
				if (out_value !== want.value || out_last !== want.is_last ||
				    overflow !== want.ovf) begin
					fail_cnt++;
					if (fail_cnt <= 10)
						$display("mismatch: expected %h/%b/%b got %h/%b/%b",
						         want.value, want.is_last, want.ovf,
						         out_value, out_last, overflow);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int unsigned words;
		int unsigned size;
		int unsigned mid;
		int unsigned sel;
		burst_left    = 0;
		seed_reg      = '0;
		batch_fill    = 0;
		batch_ovf     = 1'b0;
		gen_a         = '0;
		gen_b         = '0;
		arst_n        <= 1'b0;
		cfg_we        <= 1'b0;
		cfg_wdata     <= '0;
		in_valid      <= 1'b0;
		element_value <= '0;
		last_element  <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int k = 0; k < PLAN_LEN; k++) begin
			if (plan[k].act == ACT_SEED)
				write_seed(plan[k].data);
			else
				send_word(plan[k].data[VALUE_W-1:0], plan[k].is_last, plan[k].typed);
		end

		words = 0;
		while (words < RAND_WORDS) begin
			if ($urandom_range(0, 3) == 0)
				write_seed(pick_seed());
			sel = $urandom_range(0, 19);
			if (sel == 0)
				size = DEPTH;
			else if (sel == 1)
				size = $urandom_range(DEPTH + 1, DEPTH + 4);
			else if (sel == 2)
				size = $urandom_range(13, DEPTH - 1);
			else
				size = $urandom_range(1, 12);
			mid = (size > 1 && $urandom_range(0, 7) == 0) ? $urandom_range(1, size - 1) : 0;
			for (int unsigned k = 0; k < size; k++) begin
				if (mid != 0 && k == mid)
					write_seed(pick_seed());
				send_word(pick_value(), k == size - 1, 1'b0);
				words++;
			end
		end

		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fail_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
